>>> hw/rtl/gem_pkg.sv
// Shared types, codes and constants of the gamepad event mapper.
package gem_pkg;

    typedef enum logic [1:0] {
        CMD_EVENT        = 2'd0,
        CMD_TAKE_CHANGED = 2'd1,
        CMD_TAKE_UI      = 2'd2,
        CMD_TAKE_COMBO   = 2'd3
    } gem_cmd_t;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_X_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_DEAD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_CENTER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_DEAD   = 2'd3;

    localparam logic [4:0] EV_TYPE_KEY = 5'd1;
    localparam logic [4:0] EV_TYPE_ABS = 5'd3;

    localparam logic [9:0] KEY_B      = 10'd304;
    localparam logic [9:0] KEY_A      = 10'd305;
    localparam logic [9:0] KEY_Y      = 10'd307;
    localparam logic [9:0] KEY_X      = 10'd308;
    localparam logic [9:0] KEY_L      = 10'd310;
    localparam logic [9:0] KEY_R      = 10'd311;
    localparam logic [9:0] KEY_SELECT = 10'd314;
    localparam logic [9:0] KEY_START  = 10'd315;

    localparam logic [9:0] ABS_STICK_X = 10'd0;
    localparam logic [9:0] ABS_STICK_Y = 10'd1;
    localparam logic [9:0] ABS_HAT_X   = 10'd16;
    localparam logic [9:0] ABS_HAT_Y   = 10'd17;

    // Button mask bit positions
    localparam int unsigned BIT_A      = 0;
    localparam int unsigned BIT_B      = 1;
    localparam int unsigned BIT_SELECT = 2;
    localparam int unsigned BIT_START  = 3;
    localparam int unsigned BIT_R      = 8;
    localparam int unsigned BIT_L      = 9;
    localparam int unsigned BIT_X      = 10;
    localparam int unsigned BIT_Y      = 11;

    // Direction nibble: bit 0 right, 1 left, 2 up, 3 down
    localparam logic [3:0] DIR_RIGHT = 4'b0001;
    localparam logic [3:0] DIR_LEFT  = 4'b0010;
    localparam logic [3:0] DIR_UP    = 4'b0100;
    localparam logic [3:0] DIR_DOWN  = 4'b1000;
    localparam logic [3:0] DIR_HORIZ = 4'b0011;
    localparam logic [3:0] DIR_VERT  = 4'b1100;

    localparam logic [3:0] UI_NONE    = 4'd0;
    localparam logic [3:0] UI_CONFIRM = 4'd1;
    localparam logic [3:0] UI_DELETE  = 4'd2;
    localparam logic [3:0] UI_BACK    = 4'd3;
    localparam logic [3:0] UI_START   = 4'd4;
    localparam logic [3:0] UI_LEFT    = 4'd5;
    localparam logic [3:0] UI_RIGHT   = 4'd6;
    localparam logic [3:0] UI_UP      = 4'd7;
    localparam logic [3:0] UI_DOWN    = 4'd8;

    typedef struct packed {
        logic signed [31:0] x_center;
        logic [30:0]        x_dead;
        logic signed [31:0] y_center;
        logic [30:0]        y_dead;
    } gem_cfg_t;

    typedef struct packed {
        gem_cmd_t           command;
        logic [4:0]         event_type;
        logic [9:0]         event_code;
        logic signed [31:0] event_value;
    } gem_item_t;

    typedef struct packed {
        logic [11:0] button_mask;
        logic        changed_flag;
        logic [3:0]  ui_action;
        logic        exit_combo;
    } gem_result_t;

    typedef struct packed {
        logic [11:0] button_bits;
        logic [3:0]  dpad_bits;
        logic [3:0]  stick_bits;
        logic        start_held;
        logic        left_held;
        logic        right_held;
        logic        change_pending;
        logic        combo_pending;
        logic [3:0]  pending_ui;
    } gem_state_t;

endpackage

>>> hw/rtl/gem_in_if.sv
// Request channel carrying one input event or take command.
interface gem_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [4:0]  event_type;
    logic [9:0]  event_code;
    logic [31:0] event_value;

    modport source (output valid, output command, output event_type, output event_code,
                    output event_value, input ready);
    modport sink   (input valid, input command, input event_type, input event_code,
                    input event_value, output ready);
endinterface

>>> hw/rtl/gem_out_if.sv
// Result channel carrying the button mask and status flags.
interface gem_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] button_mask;
    logic        changed_flag;
    logic [3:0]  ui_action;
    logic        exit_combo;

    modport source (output valid, output button_mask, output changed_flag,
                    output ui_action, output exit_combo, input ready);
    modport sink   (input valid, input button_mask, input changed_flag,
                    input ui_action, input exit_combo, output ready);
endinterface

>>> hw/rtl/gem_update.sv
// Next-state and result logic for one request of the event mapper.
module gem_update (
    input  gem_pkg::gem_cfg_t    cfg,
    input  gem_pkg::gem_state_t  state,
    input  gem_pkg::gem_item_t   item,
    output gem_pkg::gem_state_t  state_next,
    output gem_pkg::gem_result_t result
);
    import gem_pkg::*;

    gem_state_t         ev_state;
    logic [11:0]        key_btn;
    logic               pressed;
    logic [11:0]        key_bits;
    logic               is_hat;
    logic               is_stick;
    logic               horiz;
    logic signed [32:0] center;
    logic signed [32:0] dead;
    logic signed [32:0] value;
    logic signed [32:0] lo;
    logic signed [32:0] hi;
    logic               below;
    logic               above;
    logic [3:0]         src;
    logic [3:0]         dir;
    logic [3:0]         src_new;
    logic [3:0]         dpad_new;
    logic [3:0]         stick_new;
    logic [11:0]        merged;

    // Axis decode and 33-bit dead-zone bounds
    always_comb begin
        is_hat   = (item.event_code == ABS_HAT_X) || (item.event_code == ABS_HAT_Y);
        is_stick = (item.event_code == ABS_STICK_X) || (item.event_code == ABS_STICK_Y);
        horiz    = (item.event_code == ABS_HAT_X) || (item.event_code == ABS_STICK_X);
        value    = {item.event_value[31], item.event_value};
        if (is_hat) begin
            center = '0;
            dead   = '0;
        end else if (horiz) begin
            center = {cfg.x_center[31], cfg.x_center};
            dead   = {2'b00, cfg.x_dead};
        end else begin
            center = {cfg.y_center[31], cfg.y_center};
            dead   = {2'b00, cfg.y_dead};
        end
        lo    = center - dead;
        hi    = center + dead;
        below = value < lo;
        above = value > hi;
        if (below) begin
            dir = horiz ? DIR_LEFT : DIR_UP;
        end else if (above) begin
            dir = horiz ? DIR_RIGHT : DIR_DOWN;
        end else begin
            dir = '0;
        end
        src       = is_hat ? state.dpad_bits : state.stick_bits;
        src_new   = (src & ~(horiz ? DIR_HORIZ : DIR_VERT)) | dir;
        dpad_new  = is_hat ? src_new : state.dpad_bits;
        stick_new = is_hat ? state.stick_bits : src_new;
        merged    = {state.button_bits[11:8], dpad_new | stick_new, state.button_bits[3:0]};
    end

    // Key decode
    always_comb begin
        key_btn = '0;
        unique case (item.event_code)
            KEY_B:      key_btn[BIT_B]      = 1'b1;
            KEY_A:      key_btn[BIT_A]      = 1'b1;
            KEY_Y:      key_btn[BIT_Y]      = 1'b1;
            KEY_X:      key_btn[BIT_X]      = 1'b1;
            KEY_SELECT: key_btn[BIT_SELECT] = 1'b1;
            KEY_START:  key_btn[BIT_START]  = 1'b1;
            KEY_L:      key_btn[BIT_L]      = 1'b1;
            KEY_R:      key_btn[BIT_R]      = 1'b1;
            default:    key_btn = '0;
        endcase
        pressed  = item.event_value != '0;
        key_bits = pressed ? (state.button_bits | key_btn) : (state.button_bits & ~key_btn);
    end

    // Apply the event
    always_comb begin
        ev_state = state;
        if (item.event_type == EV_TYPE_KEY) begin
            ev_state.button_bits = key_bits;
            if (key_bits != state.button_bits) begin
                ev_state.change_pending = 1'b1;
            end
            if (item.event_code == KEY_START) begin
                ev_state.start_held = pressed;
            end
            if (item.event_code == KEY_L) begin
                ev_state.left_held = pressed;
            end
            if (item.event_code == KEY_R) begin
                ev_state.right_held = pressed;
            end
            if (ev_state.start_held && ev_state.left_held && ev_state.right_held) begin
                ev_state.combo_pending = 1'b1;
            end
            if ((item.event_value == 32'sd1) && (state.pending_ui == UI_NONE)) begin
                unique case (item.event_code)
                    KEY_A:     ev_state.pending_ui = UI_CONFIRM;
                    KEY_B:     ev_state.pending_ui = UI_DELETE;
                    KEY_X:     ev_state.pending_ui = UI_BACK;
                    KEY_START: ev_state.pending_ui = UI_START;
                    default:   ev_state.pending_ui = state.pending_ui;
                endcase
            end
        end else if ((item.event_type == EV_TYPE_ABS) && (is_hat || is_stick)) begin
            // Merge only when the source actually moved
            if (src_new != src) begin
                ev_state.dpad_bits   = dpad_new;
                ev_state.stick_bits  = stick_new;
                ev_state.button_bits = merged;
                if (merged != state.button_bits) begin
                    ev_state.change_pending = 1'b1;
                end
            end
            if ((state.pending_ui == UI_NONE) && (below || above)) begin
                if (horiz) begin
                    ev_state.pending_ui = (value < center) ? UI_LEFT : UI_RIGHT;
                end else begin
                    ev_state.pending_ui = (value < center) ? UI_UP : UI_DOWN;
                end
            end
        end
    end

    // Result shows post-event state for events, pre-clear state for takes
    always_comb begin
        state_next = state;
        unique case (item.command)
            CMD_EVENT:        state_next = ev_state;
            CMD_TAKE_CHANGED: state_next.change_pending = 1'b0;
            CMD_TAKE_UI:      state_next.pending_ui = UI_NONE;
            CMD_TAKE_COMBO:   state_next.combo_pending = 1'b0;
            default:          state_next = state;
        endcase
        if (item.command == CMD_EVENT) begin
            result.button_mask  = ev_state.button_bits;
            result.changed_flag = ev_state.change_pending;
            result.ui_action    = ev_state.pending_ui;
            result.exit_combo   = ev_state.combo_pending;
        end else begin
            result.button_mask  = state.button_bits;
            result.changed_flag = state.change_pending;
            result.ui_action    = state.pending_ui;
            result.exit_combo   = state.combo_pending;
        end
    end

endmodule

>>> hw/rtl/gamepad_event_mapper_top.sv
// Top level of the gamepad event mapper: request/result staging and state.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-------------------------------------------
//   in_ch    | in  | valid/ready      | command, event_type, event_code, event_value
//   out_ch   | out | valid/ready      | button_mask, changed_flag, ui_action,
//            |     |                  | exit_combo
//   cfg      | in  | cfg_we (no wait) | cfg_index, cfg_data
//
// One request per cycle sustained while out_ch.ready stays high. A request
// is held in the input register, then the update logic writes the state and
// the result register in the same edge, once the result stage is free.
// Reset clears the state, the stick configuration and both valid flags.
// A stalled result holds; the input register still takes one more request,
// then in_ch.ready drops until the result is taken.
module gamepad_event_mapper_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gem_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gem_pkg::CFG_DATA_W-1:0]       cfg_data,
    gem_in_if.sink                               in_ch,
    gem_out_if.source                            out_ch
);
    import gem_pkg::*;

    gem_cfg_t    cfg_reg;
    gem_state_t  state_reg;
    gem_state_t  state_next;
    gem_item_t   item_reg;
    logic        item_valid_reg;
    gem_result_t result_reg;
    gem_result_t result_next;
    logic        result_valid_reg;
    logic        advance;

    // Move the held request into the result stage when that stage is free
    assign advance     = item_valid_reg && (!result_valid_reg || out_ch.ready);
    assign in_ch.ready = !item_valid_reg || advance;

    // Configuration writes; all four indexes are defined
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_X_CENTER: cfg_reg.x_center <= cfg_data;
                CFG_X_DEAD:   cfg_reg.x_dead   <= cfg_data[30:0];
                CFG_Y_CENTER: cfg_reg.y_center <= cfg_data;
                CFG_Y_DEAD:   cfg_reg.y_dead   <= cfg_data[30:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // Input register: capture a request on acceptance
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end else if (in_ch.ready) begin
            item_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ch.valid && in_ch.ready) begin
            item_reg.command     <= gem_cmd_t'(in_ch.command);
            item_reg.event_type  <= in_ch.event_type;
            item_reg.event_code  <= in_ch.event_code;
            item_reg.event_value <= in_ch.event_value;
        end
    end

    gem_update u_update (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // State advances exactly once per request, in order
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register: fill on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (out_ch.ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid        = result_valid_reg;
    assign out_ch.button_mask  = result_reg.button_mask;
    assign out_ch.changed_flag = result_reg.changed_flag;
    assign out_ch.ui_action    = result_reg.ui_action;
    assign out_ch.exit_combo   = result_reg.exit_combo;

endmodule

>>> hw/rtl/gem_checker.sv
// Port-level assertions for the gamepad event mapper, bound to the top level.
module gem_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] button_mask,
    input logic        changed_flag,
    input logic [3:0]  ui_action,
    input logic        exit_combo
);
    import gem_pkg::*;

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(button_mask)
            && $stable(changed_flag) && $stable(ui_action) && $stable(exit_combo))
        else $error("stalled result changed");

    // Input backpressure only comes from a stalled full result stage
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input not ready without a stalled result");

    // Ready can only drop right after the input register was loaded
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("ready dropped without a request");

    // UI action code stays within the defined set
    a_ui_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ui_action <= UI_DOWN)
        else $error("undefined ui_action code");

endmodule

bind gamepad_event_mapper_top gem_checker u_gem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .button_mask  (out_ch.button_mask),
    .changed_flag (out_ch.changed_flag),
    .ui_action    (out_ch.ui_action),
    .exit_combo   (out_ch.exit_combo)
);
